// ----- sv/touch_gesture_classifier_assert.svh -----
// ----------------------------------------------------------------------------
// touch_gesture_classifier assertion macros
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH
`define TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS

// checked at every edge, disabled while reset is high
`define TGC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define TGC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TGC_ASSERT(lbl, clk, rst, prop, msg)
`define TGC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- sv/tgc_pkg.sv -----
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types and constants of the touch gesture classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tgc_pkg;

  localparam int COORD_BITS_DEF = 10;   // internal coordinate width
  localparam int POS_BITS       = 10;   // coordinate field width on the ports
  localparam int TIME_BITS      = 32;
  localparam int HOLD_BITS      = 16;
  localparam int RADIUS_BITS    = 10;
  localparam int TRAVEL_BITS    = 10;
  localparam int SLOP_SQ_BITS   = 2 * RADIUS_BITS;
  localparam int KIND_BITS      = 3;
  localparam int ADDR_BITS      = 4;
  localparam int DATA_BITS      = 32;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_HOLD_TIME = 2'd0;
  localparam logic [1:0] REG_SLOP      = 2'd1;
  localparam logic [1:0] REG_SWIPE_MIN = 2'd2;

  localparam logic [HOLD_BITS-1:0]   HOLD_TIME_RST = 16'd600;
  localparam logic [RADIUS_BITS-1:0] SLOP_RST      = 10'd18;
  localparam logic [TRAVEL_BITS-1:0] SWIPE_MIN_RST = 10'd40;

  // gesture codes
  localparam logic [KIND_BITS-1:0] GK_NONE       = 3'd0;
  localparam logic [KIND_BITS-1:0] GK_TAP        = 3'd1;
  localparam logic [KIND_BITS-1:0] GK_HOLD_START = 3'd2;
  localparam logic [KIND_BITS-1:0] GK_HOLD_END   = 3'd3;
  localparam logic [KIND_BITS-1:0] GK_SWIPE_UP   = 3'd4;
  localparam logic [KIND_BITS-1:0] GK_SWIPE_DOWN = 3'd5;

  typedef struct packed {
    logic                 touch_down;
    logic [POS_BITS-1:0]  pos_x;
    logic [POS_BITS-1:0]  pos_y;
    logic [TIME_BITS-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] gesture_kind;
    logic [POS_BITS-1:0]  gesture_x;
    logic [POS_BITS-1:0]  gesture_y;
  } result_t;

  // settings as seen by the classifier; slop_sq is kept precomputed
  typedef struct packed {
    logic [HOLD_BITS-1:0]    hold_time_ms;
    logic [SLOP_SQ_BITS-1:0] slop_sq;
    logic [TRAVEL_BITS-1:0]  swipe_min_travel;
  } cfg_t;

endpackage

`default_nettype wire

// ----- sv/tgc_dist.sv -----
// ----------------------------------------------------------------------------
// tgc_dist
// Squared distance of two points compared with the squared slop radius.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_dist #(
  parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF
) (
  input  wire logic [COORD_BITS-1:0]           ax,
  input  wire logic [COORD_BITS-1:0]           ay,
  input  wire logic [COORD_BITS-1:0]           bx,
  input  wire logic [COORD_BITS-1:0]           by,
  input  wire logic [tgc_pkg::SLOP_SQ_BITS-1:0] slop_sq,
  output logic                                 near
);
  import tgc_pkg::*;

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 1;
  localparam int CMP_W = (SUM_W > SLOP_SQ_BITS) ? SUM_W : SLOP_SQ_BITS;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [SQ_W-1:0]       sq_x;
  logic [SQ_W-1:0]       sq_y;
  logic [SUM_W-1:0]      sum;

  assign dx   = (ax >= bx) ? ax - bx : bx - ax;
  assign dy   = (ay >= by) ? ay - by : by - ay;
  assign sq_x = {{COORD_BITS{1'b0}}, dx} * {{COORD_BITS{1'b0}}, dx};
  assign sq_y = {{COORD_BITS{1'b0}}, dy} * {{COORD_BITS{1'b0}}, dy};
  assign sum  = {1'b0, sq_x} + {1'b0, sq_y};
  assign near = CMP_W'(sum) <= CMP_W'(slop_sq);

endmodule

`default_nettype wire

// ----- sv/tgc_core.sv -----
// ----------------------------------------------------------------------------
// tgc_core
// Press tracking state and gesture decision for one sample per step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "touch_gesture_classifier_assert.svh"

module tgc_core #(
  parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire tgc_pkg::sample_t sample,
  input  wire tgc_pkg::cfg_t    cfg,
  output tgc_pkg::result_t      result_next
);
  import tgc_pkg::*;

  localparam int CMP_W = (COORD_BITS > TRAVEL_BITS) ? COORD_BITS : TRAVEL_BITS;

  logic                  pressed;
  logic                  hold_reported;
  logic [TIME_BITS-1:0]  press_time;
  logic [COORD_BITS-1:0] press_x;
  logic [COORD_BITS-1:0] press_y;
  logic [COORD_BITS-1:0] last_x;
  logic [COORD_BITS-1:0] last_y;

  logic                  pressed_next;
  logic                  hold_reported_next;
  logic [TIME_BITS-1:0]  press_time_next;
  logic [COORD_BITS-1:0] press_x_next;
  logic [COORD_BITS-1:0] press_y_next;
  logic [COORD_BITS-1:0] last_x_next;
  logic [COORD_BITS-1:0] last_y_next;

  logic [COORD_BITS-1:0] x;
  logic [COORD_BITS-1:0] y;
  logic [COORD_BITS-1:0] ox;
  logic [COORD_BITS-1:0] oy;
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  hold_due;
  logic                  near;
  logic [KIND_BITS-1:0]  kind;

  assign x = COORD_BITS'(sample.pos_x);
  assign y = COORD_BITS'(sample.pos_y);

  // one distance unit: live point while down, last point on release
  assign ox = sample.touch_down ? x : last_x;
  assign oy = sample.touch_down ? y : last_y;

  tgc_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .ax      (ox),
    .ay      (oy),
    .bx      (press_x),
    .by      (press_y),
    .slop_sq (cfg.slop_sq),
    .near    (near)
  );

  assign elapsed  = sample.now_ms - press_time;   // wraps modulo 2^32
  assign hold_due = elapsed >= TIME_BITS'(cfg.hold_time_ms);
  assign adx      = (last_x >= press_x) ? last_x - press_x : press_x - last_x;
  assign ady      = (last_y >= press_y) ? last_y - press_y : press_y - last_y;

  always_comb begin
    pressed_next       = pressed;
    hold_reported_next = hold_reported;
    press_time_next    = press_time;
    press_x_next       = press_x;
    press_y_next       = press_y;
    last_x_next        = last_x;
    last_y_next        = last_y;
    kind               = GK_NONE;
    if (sample.touch_down && !pressed) begin
      pressed_next       = 1'b1;
      hold_reported_next = 1'b0;
      press_time_next    = sample.now_ms;
      press_x_next       = x;
      press_y_next       = y;
      last_x_next        = x;
      last_y_next        = y;
    end else if (sample.touch_down) begin
      last_x_next = x;
      last_y_next = y;
      if (!hold_reported && hold_due && near) begin
        hold_reported_next = 1'b1;
        kind               = GK_HOLD_START;
      end
    end else if (pressed) begin
      pressed_next       = 1'b0;
      hold_reported_next = 1'b0;
      if (hold_reported) begin
        kind = GK_HOLD_END;
      end else if (near) begin
        kind = GK_TAP;
      end else if (CMP_W'(ady) >= CMP_W'(cfg.swipe_min_travel) && ady > adx) begin
        kind = (last_y < press_y) ? GK_SWIPE_UP : GK_SWIPE_DOWN;
      end
    end
  end

  assign result_next.gesture_kind = kind;
  assign result_next.gesture_x    = (kind != GK_NONE) ? POS_BITS'(press_x) : '0;
  assign result_next.gesture_y    = (kind != GK_NONE) ? POS_BITS'(press_y) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed       <= 1'b0;
      hold_reported <= 1'b0;
    end else if (step) begin
      pressed       <= pressed_next;
      hold_reported <= hold_reported_next;
    end
  end

  // press point and time are only read once a press has set them
  always_ff @(posedge clk) begin
    if (step) begin
      press_time <= press_time_next;
      press_x    <= press_x_next;
      press_y    <= press_y_next;
      last_x     <= last_x_next;
      last_y     <= last_y_next;
    end
  end

  `TGC_ASSERT(a_hold_needs_press, clk, rst, hold_reported |-> pressed, "hold flag without press")
  `TGC_ASSERT(a_gesture_in_press, clk, rst, (step && kind != GK_NONE) |-> pressed, "gesture while released")
  `TGC_ASSERT(a_hold_start_sets, clk, rst, (step && kind == GK_HOLD_START) |=> hold_reported, "hold start not latched")

endmodule

`default_nettype wire

// ----- sv/tgc_cfg.sv -----
// ----------------------------------------------------------------------------
// tgc_cfg
// APB register file: hold time, slop radius, minimum swipe travel.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tgc_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [tgc_pkg::DATA_BITS-1:0] pwdata,
  output logic      [tgc_pkg::DATA_BITS-1:0] prdata,
  output logic                               pready,
  output tgc_pkg::cfg_t                      cfg
);
  import tgc_pkg::*;

  logic [HOLD_BITS-1:0]    hold_time_ms;
  logic [RADIUS_BITS-1:0]  slop_radius;
  logic [TRAVEL_BITS-1:0]  swipe_min_travel;
  logic [SLOP_SQ_BITS-1:0] slop_sq;
  logic [RADIUS_BITS-1:0]  slop_wr;
  logic                    wr;

  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign slop_wr = pwdata[RADIUS_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time_ms     <= HOLD_TIME_RST;
      slop_radius      <= SLOP_RST;
      slop_sq          <= SLOP_SQ_BITS'(SLOP_RST) * SLOP_SQ_BITS'(SLOP_RST);
      swipe_min_travel <= SWIPE_MIN_RST;
    end else if (wr) begin
      case (paddr[3:2])
        REG_HOLD_TIME: hold_time_ms <= pwdata[HOLD_BITS-1:0];
        REG_SLOP: begin
          slop_radius <= slop_wr;
          slop_sq     <= {{RADIUS_BITS{1'b0}}, slop_wr} * {{RADIUS_BITS{1'b0}}, slop_wr};
        end
        REG_SWIPE_MIN: swipe_min_travel <= pwdata[TRAVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HOLD_TIME: prdata = DATA_BITS'(hold_time_ms);
      REG_SLOP:      prdata = DATA_BITS'(slop_radius);
      REG_SWIPE_MIN: prdata = DATA_BITS'(swipe_min_travel);
      default:       prdata = '0;
    endcase
  end

  assign cfg.hold_time_ms     = hold_time_ms;
  assign cfg.slop_sq          = slop_sq;
  assign cfg.swipe_min_travel = swipe_min_travel;

endmodule

`default_nettype wire

// ----- sv/touch_gesture_classifier.sv -----
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// Turns touch samples into tap, hold start/end and vertical swipe gestures.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake                      word
//   --------  ---  -----------------------------  --------------------------
//   sample    in   sample_valid / sample_ready    touch_down, pos_x/y, now_ms
//   gesture   out  gesture_valid / gesture_ready  gesture_kind, gesture_x/y
//   apb       in   psel, penable, pwrite, pready  hold, slop, swipe minimum
//
// One word in, one word out, one word per cycle sustained while gesture_ready
// is high; a word passes the input register, then the result register after
// the classifier. Press state moves as a word enters the result register, and
// the next sample sees it. Synchronous active-high reset empties both
// registers, clears the press flags and restores 600 ms, 18 px and 40 px.
// A stalled gesture holds its word; one more sample fills the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_gesture_classifier #(
  parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // sample channel
  input  wire logic                          sample_valid,
  output logic                               sample_ready,
  input  wire tgc_pkg::sample_t              sample,
  // gesture channel
  output logic                               gesture_valid,
  input  wire logic                          gesture_ready,
  output tgc_pkg::result_t                   gesture,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tgc_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [tgc_pkg::DATA_BITS-1:0] pwdata,
  output logic      [tgc_pkg::DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import tgc_pkg::*;

  logic    stage_valid;   // input register holds a sample
  sample_t stage_word;
  logic    advance;       // result register can take a word this cycle
  logic    step;          // sample moves into the result register
  cfg_t    cfg;
  result_t result_next;

  // result register frees up when empty or when its word is being taken
  assign advance      = !gesture_valid || gesture_ready;
  assign step         = stage_valid && advance;
  assign sample_ready = !stage_valid || advance;

  tgc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tgc_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .sample      (stage_word),
    .cfg         (cfg),
    .result_next (result_next)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid   <= 1'b0;
      gesture_valid <= 1'b0;
    end else begin
      if (sample_ready) begin
        stage_valid <= sample_valid;
      end
      if (advance) begin
        gesture_valid <= stage_valid;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      stage_word <= sample;
    end
    if (step) begin
      gesture <= result_next;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/touch_gesture_classifier_test.sv -----
// ----------------------------------------------------------------------------
// touch_gesture_classifier_test
// Self-checking bench for the touch gesture classifier. Touch sample words
// go in on a valid/ready channel, gesture words come back one per sample and
// are compared field by field with a bench classifier or a row's own word.
// Settings go in over the APB port, only while the block is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_gesture_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tgc_pkg::*;

  // register index with nothing behind it, writes must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic UP    = 1'b0;
  localparam logic DOWN  = 1'b1;
  localparam logic TYPED = 1'b1;   // row carries its own expected word
  localparam logic MODEL = 1'b0;   // row is checked against the classifier

  localparam result_t NOTHING = '{GK_NONE, 10'd0, 10'd0};

  // run ends here whatever happens; the real run is a few tens of microseconds
  localparam int unsigned LIMIT_NS = 5_000_000;

  // --------------------------------------------------------------------------
  // Block signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 sample_valid  = 1'b0;
  logic                 sample_ready;
  sample_t              sample        = '0;
  logic                 gesture_valid;
  logic                 gesture_ready = 1'b0;
  result_t              gesture;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [ADDR_BITS-1:0] paddr         = '0;
  logic [DATA_BITS-1:0] pwdata        = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  touch_gesture_classifier u_dut (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample        (sample),
    .gesture_valid (gesture_valid),
    .gesture_ready (gesture_ready),
    .gesture       (gesture),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Classifier kept by the bench: its own settings and press state
  // --------------------------------------------------------------------------
  logic [HOLD_BITS-1:0]   want_hold   = HOLD_TIME_RST;
  logic [RADIUS_BITS-1:0] want_slop   = SLOP_RST;
  logic [TRAVEL_BITS-1:0] want_travel = SWIPE_MIN_RST;

  logic                 finger_held  = 1'b0;
  logic                 hold_flagged = 1'b0;
  logic [TIME_BITS-1:0] press_ms     = '0;
  logic [POS_BITS-1:0]  press_px     = '0;
  logic [POS_BITS-1:0]  press_py     = '0;
  logic [POS_BITS-1:0]  last_px      = '0;
  logic [POS_BITS-1:0]  last_py      = '0;

  result_t gestures_due [$];   // expected gesture words, oldest first
  int      faults = 0;
  bit      steady = 1'b0;      // set: neither side idles

  function automatic int axis_span(input logic [POS_BITS-1:0] a, input logic [POS_BITS-1:0] b);
    return (a >= b) ? int'(a - b) : int'(b - a);
  endfunction

  // squared distance against squared radius, no rounding, no overflow
  function automatic bit near_press(input logic [POS_BITS-1:0] x, input logic [POS_BITS-1:0] y);
    longint dx;
    longint dy;
    longint r;
    dx = axis_span(x, press_px);
    dy = axis_span(y, press_py);
    r  = want_slop;
    return (dx * dx + dy * dy) <= r * r;
  endfunction

  function automatic result_t classify_touch(input sample_t s);
    result_t              r;
    logic [TIME_BITS-1:0] held_for;
    int                   dx;
    int                   dy;
    r        = NOTHING;
    held_for = s.now_ms - press_ms;   // wraps modulo 2^32 by width
    if (s.touch_down && !finger_held) begin
      // fresh press: remember where and when, report nothing
      finger_held  = 1'b1;
      hold_flagged = 1'b0;
      press_ms     = s.now_ms;
      press_px     = s.pos_x;
      press_py     = s.pos_y;
      last_px      = s.pos_x;
      last_py      = s.pos_y;
    end else if (s.touch_down) begin
      last_px = s.pos_x;
      last_py = s.pos_y;
      // hold start only once, and only while still inside the slop circle
      if (!hold_flagged && held_for >= TIME_BITS'(want_hold) && near_press(s.pos_x, s.pos_y)) begin
        hold_flagged   = 1'b1;
        r.gesture_kind = GK_HOLD_START;
      end
    end else if (finger_held) begin
      // release: position of the release word itself plays no part
      finger_held = 1'b0;
      if (hold_flagged) begin
        r.gesture_kind = GK_HOLD_END;
      end else if (near_press(last_px, last_py)) begin
        r.gesture_kind = GK_TAP;
      end else begin
        dx = axis_span(last_px, press_px);
        dy = axis_span(last_py, press_py);
        if (dy >= int'(want_travel) && dy > dx) begin
          r.gesture_kind = (last_py < press_py) ? GK_SWIPE_UP : GK_SWIPE_DOWN;
        end
      end
      hold_flagged = 1'b0;
    end
    // finger up while not pressed falls through untouched
    if (r.gesture_kind != GK_NONE) begin
      r.gesture_x = press_px;
      r.gesture_y = press_py;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report(input string what);
    faults++;
    $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  // --------------------------------------------------------------------------
  // Gesture side: random back-pressure and field-by-field compare
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      gesture_ready <= 1'b0;
    end else begin
      if (gesture_valid && gesture_ready) begin
        if (gestures_due.size() == 0) begin
          report($sformatf("gesture word kind %0d with nothing outstanding",
                           gesture.gesture_kind));
        end else begin
          want = gestures_due.pop_front();
          if (gesture.gesture_kind !== want.gesture_kind)
            report($sformatf("gesture_kind got %0d want %0d",
                             gesture.gesture_kind, want.gesture_kind));
          if (gesture.gesture_x !== want.gesture_x)
            report($sformatf("gesture_x got %0d want %0d",
                             gesture.gesture_x, want.gesture_x));
          if (gesture.gesture_y !== want.gesture_y)
            report($sformatf("gesture_y got %0d want %0d",
                             gesture.gesture_y, want.gesture_y));
        end
      end
      gesture_ready <= steady || ($urandom_range(99) >= 34);
    end
  end

  // --------------------------------------------------------------------------
  // Sample side
  // --------------------------------------------------------------------------
  // One word in; the expectation is queued at the edge that takes it. Random
  // gaps follow, unless steady is set, so that idle cycles land on every stage of the pipe.
  task automatic push_sample(input sample_t s, input logic typed, input result_t want);
    result_t model;
    sample       <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    model = classify_touch(s);
    gestures_due.push_back(typed ? want : model);
    if (!steady && $urandom_range(99) < 34) begin
      sample_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 34);
    end
  endtask

  // sender holds off until every gesture word is back
  task automatic drain();
    sample_valid <= 1'b0;
    while (gestures_due.size() != 0) @(posedge clk);
  endtask

  // APB write: setup, access, a quiet bus, then a read of the same slot
  task automatic write_register(input logic [1:0] idx, input logic [DATA_BITS-1:0] value);
    logic [DATA_BITS-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_HOLD_TIME: want_hold   = value[HOLD_BITS-1:0];
      REG_SLOP:      want_slop   = value[RADIUS_BITS-1:0];
      REG_SWIPE_MIN: want_travel = value[TRAVEL_BITS-1:0];
      default: ;   // unmapped index, block ignores it
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    // unmapped slot reads as zero
    case (idx)
      REG_HOLD_TIME: readback = DATA_BITS'(want_hold);
      REG_SLOP:      readback = DATA_BITS'(want_slop);
      REG_SWIPE_MIN: readback = DATA_BITS'(want_travel);
      default:       readback = '0;
    endcase
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== readback)
      report($sformatf("register %0d reads %0h want %0h", idx, prdata, readback));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input int hold, input int slop, input int travel);
    drain();
    write_register(REG_HOLD_TIME, hold);
    write_register(REG_SLOP, slop);
    write_register(REG_SWIPE_MIN, travel);
  endtask

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic [POS_BITS-1:0] on_panel(input int v);
    return (v < 0) ? '0 : (v > 1023) ? 10'd1023 : POS_BITS'(v);
  endfunction

  // Mostly well-formed press/move/release strokes with random content; the
  // rest is raw noise (lone releases, stray presses, anything at all).
  task automatic play_gestures(input int count);
    int                   sent;
    int                   moves;
    int                   px;
    int                   py;
    int                   s_r;
    int                   dx;
    int                   dy;
    logic [TIME_BITS-1:0] t0;
    logic [TIME_BITS-1:0] off;
    sample_t              s;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 20) begin
        s.touch_down = $urandom_range(0, 1);
        s.pos_x      = $urandom_range(0, 1023);
        s.pos_y      = $urandom_range(0, 1023);
        s.now_ms     = $urandom;
        push_sample(s, MODEL, NOTHING);
        sent++;
      end else begin
        px = $urandom_range(0, 1023);
        py = $urandom_range(0, 1023);
        // some presses sit just below the timestamp wrap
        t0 = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000) : $urandom;
        s.touch_down = DOWN;
        s.pos_x      = px;
        s.pos_y      = py;
        s.now_ms     = t0;
        push_sample(s, MODEL, NOTHING);
        moves = $urandom_range(0, 5);
        s_r   = want_slop;
        for (int m = 0; m < moves; m++) begin
          case ($urandom_range(0, 4))
            0: off = $urandom_range(0, want_hold);
            1: off = want_hold + $urandom_range(0, 3);
            2: off = (want_hold == 0) ? '0 : want_hold - 1;
            3: off = $urandom;
            default: off = want_hold + $urandom_range(0, 3000);
          endcase
          case ($urandom_range(0, 4))
            0: begin
              dx = pick(-s_r, s_r);
              dy = pick(-s_r, s_r);
            end
            1: begin   // on or just past the slop circle
              dx = $urandom_range(1) ? s_r : -s_r;
              dy = pick(-1, 1);
            end
            2: begin   // vertical travel around the swipe minimum
              dy = int'(want_travel) + pick(-2, 30);
              dy = $urandom_range(1) ? dy : -dy;
              dx = pick(-20, 20);
            end
            3: begin
              dx = pick(0, 1023) - px;
              dy = pick(0, 1023) - py;
            end
            default: begin
              dx = 0;
              dy = 0;
            end
          endcase
          s.touch_down = DOWN;
          s.pos_x      = on_panel(px + dx);
          s.pos_y      = on_panel(py + dy);
          s.now_ms     = t0 + off;
          push_sample(s, MODEL, NOTHING);
        end
        s.touch_down = UP;
        s.pos_x      = $urandom_range(0, 1023);
        s.pos_y      = $urandom_range(0, 1023);
        s.now_ms     = t0 + $urandom_range(0, 70000);
        push_sample(s, MODEL, NOTHING);
        sent += moves + 2;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed words, reset settings: hold 600 ms, slop 18 px, swipe 40 px
  // --------------------------------------------------------------------------
  typedef struct packed {
    sample_t smp;
    logic    typed;
    result_t want;
  } touch_row_t;

  touch_row_t plan [0:24] = '{
    // finger up with nothing pressed, all fields at their top
    '{'{UP,   10'd1023, 10'd1023, 32'hFFFF_FFFF}, TYPED, '{GK_NONE, 10'd0, 10'd0}},
    // press at the far corner just before the timestamp wraps
    '{'{DOWN, 10'd1023, 10'd1023, 32'hFFFF_FF00}, TYPED, '{GK_NONE, 10'd0, 10'd0}},
    '{'{DOWN, 10'd1023, 10'd1023, 32'h0000_0157}, MODEL, '{GK_NONE, 10'd0, 10'd0}},
    // 600 ms across the wrap: hold starts
    '{'{DOWN, 10'd1023, 10'd1023, 32'h0000_0158}, TYPED,
      '{GK_HOLD_START, 10'd1023, 10'd1023}},
    // hold is reported once only
    '{'{DOWN, 10'd1023, 10'd1023, 32'h0000_0200}, TYPED, '{GK_NONE, 10'd0, 10'd0}},
    '{'{UP,   10'd0,    10'd0,    32'h0000_0300}, TYPED,
      '{GK_HOLD_END, 10'd1023, 10'd1023}},
    // short press at the origin, drift inside slop, release back at the origin: tap
    '{'{DOWN, 10'd0,    10'd0,    32'd1000},      MODEL, NOTHING},
    '{'{DOWN, 10'd12,   10'd12,   32'd1599},      MODEL, NOTHING},
    '{'{UP,   10'd0,    10'd0,    32'd1600},      TYPED, '{GK_TAP, 10'd0, 10'd0}},
    // exactly on the slop radius still counts as a tap
    '{'{DOWN, 10'd500,  10'd500,  32'd2000},      MODEL, NOTHING},
    '{'{DOWN, 10'd518,  10'd500,  32'd2599},      MODEL, NOTHING},
    '{'{UP,   10'd7,    10'd900,  32'd2600},      MODEL, NOTHING},
    // long enough but outside slop: no hold, then back inside: hold
    '{'{DOWN, 10'd500,  10'd500,  32'd3000},      MODEL, NOTHING},
    '{'{DOWN, 10'd518,  10'd501,  32'd3600},      MODEL, NOTHING},
    '{'{DOWN, 10'd500,  10'd500,  32'd3601},      MODEL, NOTHING},
    '{'{UP,   10'd500,  10'd500,  32'd3700},      MODEL, NOTHING},
    // swipe up by exactly the minimum
    '{'{DOWN, 10'd500,  10'd500,  32'd4000},      MODEL, NOTHING},
    '{'{DOWN, 10'd510,  10'd460,  32'd4010},      MODEL, NOTHING},
    '{'{UP,   10'd500,  10'd500,  32'd4020},      MODEL, NOTHING},
    // swipe down
    '{'{DOWN, 10'd500,  10'd500,  32'd5000},      MODEL, NOTHING},
    '{'{DOWN, 10'd500,  10'd540,  32'd5010},      MODEL, NOTHING},
    '{'{UP,   10'd500,  10'd500,  32'd5020},      MODEL, NOTHING},
    // diagonal, vertical equals horizontal: no gesture
    '{'{DOWN, 10'd500,  10'd500,  32'd6000},      MODEL, NOTHING},
    '{'{DOWN, 10'd540,  10'd540,  32'd6010},      MODEL, NOTHING},
    '{'{UP,   10'd500,  10'd500,  32'd6020},      TYPED, '{GK_NONE, 10'd0, 10'd0}}
  };

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sample_t s;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // a write to the unmapped slot must leave the reset settings alone
    write_register(REG_UNUSED, 32'hFFFF_FFFF);
    foreach (plan[i]) push_sample(plan[i].smp, plan[i].typed, plan[i].want);

    // back to back, no idling on either side
    steady = 1'b1;
    play_gestures(100);
    steady = 1'b0;

    // bottom of every range: instant hold, zero slop, any vertical lead swipes
    apply_settings(0, 0, 0);
    play_gestures(90);

    // top of every range; a swipe then needs the full panel height
    apply_settings(65535, 1023, 1023);
    s = '{DOWN, 10'd0, 10'd1023, 32'd10};
    push_sample(s, MODEL, NOTHING);
    s = '{DOWN, 10'd1, 10'd0, 32'd20};
    push_sample(s, MODEL, NOTHING);
    s = '{UP, 10'd1, 10'd0, 32'd30};
    push_sample(s, MODEL, NOTHING);
    play_gestures(80);

    // settings where gestures actually happen, then anything at all
    repeat (2) begin
      apply_settings($urandom_range(0, 1500), $urandom_range(0, 40), $urandom_range(0, 120));
      play_gestures(90);
    end
    apply_settings($urandom_range(0, 65535), $urandom_range(0, 1023), $urandom_range(0, 1023));
    play_gestures(60);

    // let the last words out, bounded, then a short tail for strays
    sample_valid <= 1'b0;
    for (int w = 0; w < 5000 && gestures_due.size() != 0; w++) @(posedge clk);
    if (gestures_due.size() != 0)
      report($sformatf("%0d gesture words never arrived", gestures_due.size()));
    repeat (10) @(posedge clk);

    if (faults == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/tgc_pkg.sv
sv/tgc_dist.sv
sv/tgc_core.sv
sv/tgc_cfg.sv
sv/touch_gesture_classifier.sv
tb/sv/touch_gesture_classifier_test.sv
